// File: hw/rtl/scd_pkg.sv
package scd_pkg;

	// pixel, coefficient and table widths
	localparam int PIX_W              = 8;
	localparam int COEF_W             = 16;
	localparam int OD_W               = 16;
	localparam int LEVEL_W            = 8;
	localparam int COEF_FRAC_BITS_DEF = 12;

	// fixed-point exponent path
	localparam int Q_FRAC   = 30;
	localparam int MANT_W   = Q_FRAC + 1;
	localparam int NP_W     = 5;
	localparam int STEPS    = Q_FRAC;
	localparam int ROOT_W   = 32;
	localparam int LOG_W    = 33;
	localparam int U_W      = NP_W + Q_FRAC;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_RED   = 2'd0,
		REG_GREEN = 2'd1,
		REG_BLUE  = 2'd2
	} cfg_reg_t;

	typedef logic [OD_W-1:0]   od_tab_t   [256];
	typedef logic [ROOT_W-1:0] root_tab_t [STEPS+1];

	// word handed to the exponent unit
	typedef struct packed {
		logic              vld;
		logic              pos;
		logic [NP_W-1:0]   np;
		logic [Q_FRAC-1:0] frac;
	} exp_in_t;

	// integer square root, one result bit per pass
	function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		v = v_in;
		r = '0;
		b = 64'd1 << 62;
		for (int k = 0; k < 32; k++) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// log2 in Q.30 by repeated squaring with truncation
	function automatic logic [63:0] log2_q30(input logic [31:0] x);
		logic [63:0] m;
		logic [63:0] res;
		int n;
		n = 0;
		for (int k = 0; k < 31; k++) begin
			if ((x >> (k + 1)) != 0) n = k + 1;
		end
		if (n <= 30) m = 64'(x) << (30 - n);
		else m = 64'(x) >> (n - 30);
		res = 64'(n) << 30;
		for (int i = 29; i >= 0; i--) begin
			m = (m * m) >> 30;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				res[i] = 1'b1;
			end
		end
		return res;
	endfunction

	localparam logic [63:0] LOG2_255_W = log2_q30(32'd255);
	localparam logic [LOG_W-1:0] LOG2_255 = LOG2_255_W[LOG_W-1:0];

	// optical density per channel code, unsigned Q8.8
	function automatic od_tab_t build_od();
		od_tab_t t;
		logic [63:0] l;
		for (int c = 0; c < 256; c++) begin
			l = log2_q30(32'(c + 1));
			if (l >= LOG2_255_W) t[c] = '0;
			else t[c] = OD_W'((64'd65280 * (LOG2_255_W - l) + LOG2_255_W / 2) / LOG2_255_W);
		end
		return t;
	endfunction

	// roots 2^(2^-i) in Q.30
	function automatic root_tab_t build_roots();
		root_tab_t t;
		logic [63:0] prev;
		prev = 64'd1 << 31;
		t[0] = ROOT_W'(prev);
		for (int i = 1; i <= STEPS; i++) begin
			prev = isqrt64(prev << 30);
			t[i] = ROOT_W'(prev);
		end
		return t;
	endfunction

	localparam od_tab_t   OD_TABLE   = build_od();
	localparam root_tab_t ROOT_TABLE = build_roots();

endpackage

// File: hw/rtl/scd_exp2.sv
module scd_exp2 import scd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  exp_in_t            in_word,
	output logic               out_vld,
	output logic [LEVEL_W-1:0] out_level
);

	localparam int PROD_W   = 2 * MANT_W;
	localparam int RND_BASE = Q_FRAC + 16;
	localparam int RND_W    = RND_BASE + 1;
	localparam int SH_W     = 6;
	localparam logic [MANT_W-1:0] MANT_ONE = MANT_W'(1) << Q_FRAC;

	logic              step_vld_s  [1:STEPS];
	logic              step_pos_s  [1:STEPS];
	logic [NP_W-1:0]   step_np_s   [1:STEPS];
	logic [Q_FRAC-1:0] step_frac_s [1:STEPS];
	logic [MANT_W-1:0] step_mant_s [1:STEPS];

	// one root multiply per stage, lowest fraction weight last
	for (genvar k = 1; k <= STEPS; k++) begin : g_step
		logic              vld_in;
		logic              pos_in;
		logic [NP_W-1:0]   np_in;
		logic [Q_FRAC-1:0] frac_in;
		logic [MANT_W-1:0] mant_in;
		logic [PROD_W-1:0] prod;

		if (k == 1) begin : g_first
			assign vld_in  = in_word.vld;
			assign pos_in  = in_word.pos;
			assign np_in   = in_word.np;
			assign frac_in = in_word.frac;
			assign mant_in = MANT_ONE;
		end else begin : g_next
			assign vld_in  = step_vld_s[k-1];
			assign pos_in  = step_pos_s[k-1];
			assign np_in   = step_np_s[k-1];
			assign frac_in = step_frac_s[k-1];
			assign mant_in = step_mant_s[k-1];
		end

		assign prod = PROD_W'(mant_in) * PROD_W'(ROOT_TABLE[k][MANT_W-1:0]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_vld_s[k] <= 1'b0;
			end else if (en) begin
				step_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_pos_s[k]  <= pos_in;
				step_np_s[k]   <= np_in;
				step_frac_s[k] <= frac_in;
				step_mant_s[k] <= frac_in[Q_FRAC-k] ? prod[Q_FRAC +: MANT_W] : mant_in;
			end
		end
	end

	// round half up at the binary point given by the exponent, clamp
	logic [SH_W-1:0]    shift;
	logic [RND_W-1:0]   rnd_sum;
	logic [RND_W-1:0]   rnd;
	logic [LEVEL_W-1:0] level;

	always_comb begin
		shift   = SH_W'(RND_BASE) - SH_W'(step_np_s[STEPS]);
		rnd_sum = RND_W'(step_mant_s[STEPS]) + (RND_W'(1) << (shift - SH_W'(1)));
		rnd     = rnd_sum >> shift;
		if (!step_pos_s[STEPS] || rnd > RND_W'(LEVEL_MAX)) level = LEVEL_MAX;
		else level = rnd[LEVEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= step_vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_level <= level;
		end
	end

endmodule

// File: hw/rtl/stain_color_deconvolution_pixel_top.sv
// Stain deconvolution, one RGB pixel in, one stain level out.
// Throughput: one pixel per cycle while s_axis_tready is high.
// The 30 root-multiply stages of the exponent set the pipeline depth.
// A two-word output buffer lets the pipe run on while one result waits.
// Reset (arst_n low, asynchronous): pipeline emptied, coefficients cleared to zero.
module stain_color_deconvolution_pixel_top import scd_pkg::*; #(
	parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [3*PIX_W-1:0]   s_axis_tdata,  // red [7:0], green [15:8], blue [23:16]
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [LEVEL_W-1:0]   m_axis_tdata,  // stain_level [7:0]
	input  logic                 cfg_wr_en,
	input  logic [1:0]           cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	localparam int SBITS  = 8 + COEF_FRAC_BITS;
	localparam int DW     = SBITS + 10;
	localparam int PROD_W = OD_W + COEF_W + 1;
	localparam int SUM_W  = PROD_W + 2;
	localparam int LO_W   = 17;
	localparam int HI_W   = LOG_W - LO_W;
	localparam int PL_W   = DW + LO_W;
	localparam int PH_W   = DW + HI_W;
	localparam int P_W    = DW + LOG_W;
	localparam int XW     = P_W - SBITS;
	localparam int E_W    = XW - 8;
	localparam int R_W    = 11;
	localparam int C_W    = 3;

	localparam logic [DW-1:0] D_MAX = DW'(1) << (SBITS + 9);
	localparam logic signed [SUM_W-1:0] D_MAX_S = SUM_W'(D_MAX);
	localparam logic [LO_W-1:0] L_LO = LOG2_255[LO_W-1:0];
	localparam logic [HI_W-1:0] L_HI = LOG2_255[LOG_W-1:LO_W];
	localparam logic [U_W-1:0] U_BASE = U_W'(LOG2_255) + (U_W'(16) << Q_FRAC);
	localparam logic [R_W-1:0] DIV = R_W'(255);

	// coefficient registers
	logic signed [COEF_W-1:0] coef_r_q;
	logic signed [COEF_W-1:0] coef_g_q;
	logic signed [COEF_W-1:0] coef_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_r_q <= '0;
			coef_g_q <= '0;
			coef_b_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_RED:   coef_r_q <= cfg_data;
				REG_GREEN: coef_g_q <= cfg_data;
				REG_BLUE:  coef_b_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// pipe advances while the output buffer has room
	logic en;
	logic skid_vld_q;

	assign en            = !skid_vld_q;
	assign s_axis_tready = en;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
		end
	end

	logic [PIX_W-1:0]         red_s1, green_s1, blue_s1;
	logic [OD_W-1:0]          od_r_s2, od_g_s2, od_b_s2;
	logic signed [PROD_W-1:0] prod_r_s3, prod_g_s3, prod_b_s3;
	logic signed [SUM_W-1:0]  sum;
	logic                     pos_s4, pos_s5, pos_s6, pos_s7, pos_s8, pos_s9, pos_s10;
	logic [DW-1:0]            d_s4;
	logic [PL_W-1:0]          pp_lo_s5;
	logic [PH_W-1:0]          pp_hi_s5;
	logic [P_W-1:0]           p_full;
	logic [XW-1:0]            x_s6, x_s7;
	logic [E_W-1:0]           q0_s7, q0_s8;
	logic [XW-1:0]            rem_full;
	logic [R_W-1:0]           rem_s8;
	logic [C_W-1:0]           corr;
	logic [E_W-1:0]           e_s9;
	logic [U_W-1:0]           u;
	logic [U_W-1:0]           u_s10;

	// weighted density sum
	assign sum = SUM_W'(prod_r_s3) + SUM_W'(prod_g_s3) + SUM_W'(prod_b_s3);

	// exponent numerator from two partial products, then drop the sum's fraction
	assign p_full = (P_W'(pp_hi_s5) << LO_W) + P_W'(pp_lo_s5);

	// remainder against 255 times the quotient estimate
	assign rem_full = x_s7 - (XW'(q0_s7) << 8) + XW'(q0_s7);

	// quotient estimate is low by at most six
	assign corr = C_W'(rem_s8 >= DIV) + C_W'(rem_s8 >= R_W'(2 * 255))
		+ C_W'(rem_s8 >= R_W'(3 * 255)) + C_W'(rem_s8 >= R_W'(4 * 255))
		+ C_W'(rem_s8 >= R_W'(5 * 255)) + C_W'(rem_s8 >= R_W'(6 * 255));

	// exponent offset by sixteen so it stays positive
	assign u = U_BASE - U_W'(e_s9);

	always_ff @(posedge clk) begin
		if (en) begin
			// input register
			red_s1   <= s_axis_tdata[PIX_W-1:0];
			green_s1 <= s_axis_tdata[2*PIX_W-1:PIX_W];
			blue_s1  <= s_axis_tdata[3*PIX_W-1:2*PIX_W];
			// optical density lookup
			od_r_s2  <= OD_TABLE[red_s1];
			od_g_s2  <= OD_TABLE[green_s1];
			od_b_s2  <= OD_TABLE[blue_s1];
			// coefficient weighting
			prod_r_s3 <= PROD_W'($signed({1'b0, od_r_s2})) * PROD_W'(coef_r_q);
			prod_g_s3 <= PROD_W'($signed({1'b0, od_g_s2})) * PROD_W'(coef_g_q);
			prod_b_s3 <= PROD_W'($signed({1'b0, od_b_s2})) * PROD_W'(coef_b_q);
			// sign test and saturation
			pos_s4 <= (sum > 0);
			d_s4   <= (sum > D_MAX_S) ? D_MAX : DW'(sum);
			// scale by log2 of 255
			pos_s5   <= pos_s4;
			pp_lo_s5 <= PL_W'(d_s4) * PL_W'(L_LO);
			pp_hi_s5 <= PH_W'(d_s4) * PH_W'(L_HI);
			pos_s6   <= pos_s5;
			x_s6     <= XW'(p_full >> SBITS);
			// divide by 255: series estimate, remainder, correction
			pos_s7 <= pos_s6;
			x_s7   <= x_s6;
			q0_s7  <= E_W'(x_s6 >> 8) + E_W'(x_s6 >> 16) + E_W'(x_s6 >> 24)
				+ E_W'(x_s6 >> 32) + E_W'(x_s6 >> 40);
			pos_s8 <= pos_s7;
			q0_s8  <= q0_s7;
			rem_s8 <= rem_full[R_W-1:0];
			pos_s9 <= pos_s8;
			e_s9   <= q0_s8 + E_W'(corr);
			pos_s10 <= pos_s9;
			u_s10   <= u;
		end
	end

	exp_in_t exp_in;
	logic               exp_vld;
	logic [LEVEL_W-1:0] exp_level;

	assign exp_in.vld  = vld_s10;
	assign exp_in.pos  = pos_s10;
	assign exp_in.np   = u_s10[U_W-1:Q_FRAC];
	assign exp_in.frac = u_s10[Q_FRAC-1:0];

	scd_exp2 u_exp2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_word   (exp_in),
		.out_vld   (exp_vld),
		.out_level (exp_level)
	);

	// output register with one skid word behind it
	logic               out_vld_q;
	logic [LEVEL_W-1:0] out_data_q;
	logic [LEVEL_W-1:0] skid_data_q;
	logic               take;
	logic               push;

	assign take = out_vld_q && m_axis_tready;
	assign push = en && exp_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) skid_vld_q <= 1'b0;
		end else if (push) begin
			if (!out_vld_q || take) out_vld_q <= 1'b1;
			else skid_vld_q <= 1'b1;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) out_data_q <= skid_data_q;
		end else if (push) begin
			if (!out_vld_q || take) out_data_q <= exp_level;
			else skid_data_q <= exp_level;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

endmodule

// File: sim/tb_stain_color_deconvolution_pixel_top.sv
`timescale 1ns / 1ps

module tb_stain_color_deconvolution_pixel_top;
	import scd_pkg::*;

	localparam int COEF_FRAC   = COEF_FRAC_BITS_DEF;
	localparam int SUM_FRAC    = 8 + COEF_FRAC;
	localparam int PHASE_ITEMS = 100;
	localparam int NUM_PHASES  = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int MAX_REPORTS = 40;
	localparam int DRAIN_WAIT  = 60;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [3*PIX_W-1:0]   s_axis_tdata;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [LEVEL_W-1:0]   m_axis_tdata;
	logic                 cfg_wr_en;
	logic [1:0]           cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	// local copy of the weights and of the fixed tables
	shortint              red_weight;
	shortint              green_weight;
	shortint              blue_weight;
	logic [15:0]          density_lut [256];
	longint unsigned      root_lut [31];
	longint unsigned      log2_of_255;

	logic [LEVEL_W-1:0]   expected_levels [$];
	int                   errors = 0;
	int                   cycle_count = 0;
	bit                   idle_enabled = 1'b1;

	stain_color_deconvolution_pixel_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// log2 in Q.30, squaring the mantissa and truncating each time
	function automatic longint unsigned q30_log2(input int unsigned x);
		int unsigned     msb;
		longint unsigned mant;
		longint unsigned acc;
		msb = 0;
		for (int k = 1; k < 32; k++)
			if ((x >> k) != 0) msb = k;
		mant = longint'(x) << (30 - msb);
		acc = longint'(msb) << 30;
		for (int i = 29; i >= 0; i--) begin
			mant = (mant * mant) >> 30;
			if (mant >= (64'd2 << 30)) begin
				mant = mant >> 1;
				acc[i] = 1'b1;
			end
		end
		return acc;
	endfunction

	// floor of the square root, one bit at a time from the top
	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int k = 31; k >= 0; k--) begin
			trial = root | (64'd1 << k);
			if (trial * trial <= v) root = trial;
		end
		return root;
	endfunction

	// density table and the chain of roots 2^(2^-i)
	function automatic void build_luts();
		longint unsigned lg;
		log2_of_255 = q30_log2(255);
		for (int c = 0; c < 256; c++) begin
			lg = q30_log2(c + 1);
			if (lg >= log2_of_255) density_lut[c] = '0;
			else density_lut[c] = 16'((64'd65280 * (log2_of_255 - lg) + log2_of_255 / 2)
				/ log2_of_255);
		end
		root_lut[0] = 64'd2 << 30;
		for (int i = 1; i <= 30; i++) root_lut[i] = floor_sqrt(root_lut[i-1] << 30);
	endfunction

	// stain level of one pixel under the current weights
	function automatic logic [LEVEL_W-1:0] predict_level(input logic [7:0] r, g, b);
		longint          weighted;
		longint unsigned dens;
		longint unsigned expo;
		longint unsigned u;
		longint unsigned frac;
		longint unsigned mant;
		longint unsigned lvl;
		int unsigned     whole;
		int unsigned     sh;
		weighted = longint'(density_lut[r]) * longint'(red_weight)
			+ longint'(density_lut[g]) * longint'(green_weight)
			+ longint'(density_lut[b]) * longint'(blue_weight);
		// no stain at all clamps to full intensity
		if (weighted <= 0) return LEVEL_MAX;
		dens = weighted;
		if (dens > (64'd512 << SUM_FRAC)) dens = 64'd512 << SUM_FRAC;
		expo = (dens * log2_of_255) / (64'd255 << SUM_FRAC);
		u = log2_of_255 + (64'd16 << 30) - expo;
		whole = int'(u >> 30);
		frac = u & ((64'd1 << 30) - 1);
		mant = 64'd1 << 30;
		for (int i = 1; i <= 30; i++)
			if (frac[30-i]) mant = (mant * root_lut[i]) >> 30;
		if (whole > 45) begin
			lvl = 255;
		end else begin
			sh = 46 - whole;
			lvl = (mant + (64'd1 << (sh - 1))) >> sh;
		end
		if (lvl > 255) lvl = 255;
		return lvl[7:0];
	endfunction

	function automatic int unsigned draw_idle();
		return idle_enabled ? $urandom_range(0, 10) : 0;
	endfunction

	// channel value with extra weight on the ends of the range
	function automatic logic [7:0] draw_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [15:0] draw_weight(input int unsigned span);
		return 16'($urandom_range(0, 2 * span) - span);
	endfunction

	// one register write, mirrored into the local weights
	task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_RED:   red_weight   = value;
			REG_GREEN: green_weight = value;
			REG_BLUE:  blue_weight  = value;
			default: ;
		endcase
	endtask

	// drop valid and wait for every pending word
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_levels.size() != 0) @(posedge clk);
	endtask

	task automatic set_weights(input logic [15:0] wr, wg, wb);
		settle();
		write_reg(REG_RED, wr);
		write_reg(REG_GREEN, wg);
		write_reg(REG_BLUE, wb);
	endtask

	// one pixel word, predicted at the edge where it is taken
	task automatic send_pixel(input logic [7:0] r, g, b);
		int unsigned gap;
		gap = draw_idle();
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, g, r};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_levels.push_back(predict_level(r, g, b));
	endtask

	// output side stalls a random number of cycles before each word
	initial begin : sink
		int unsigned stall;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			stall = draw_idle();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin : level_check
		logic [LEVEL_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_levels.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$error("stain_level: word with no pixel pending, actual %0d", m_axis_tdata);
			end else begin
				want = expected_levels.pop_front();
				if (m_axis_tdata !== want) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$error("stain_level: expected %0d, actual %0d", want, m_axis_tdata);
				end
			end
		end
	end

	// weights are zero after reset, so every pixel gives full intensity
	task automatic test_reset_weights();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd0, 8'd128, 8'd255);
	endtask

	// unit weight on one channel at a time, swept over that channel
	task automatic test_single_channel();
		logic [7:0] vals [3];
		logic [7:0] pix [3];
		vals = '{8'd0, 8'd128, 8'd255};
		for (int ch = 0; ch < 3; ch++) begin
			set_weights(ch == 0 ? 16'h1000 : 16'h0000, ch == 1 ? 16'h1000 : 16'h0000,
				ch == 2 ? 16'h1000 : 16'h0000);
			for (int v = 0; v < 3; v++) begin
				pix[0] = draw_channel();
				pix[1] = draw_channel();
				pix[2] = draw_channel();
				pix[ch] = vals[v];
				send_pixel(pix[0], pix[1], pix[2]);
			end
		end
	endtask

	// largest weights: dark pixel saturates the sum, white pixel gives zero sum
	task automatic test_saturated_sum();
		set_weights(16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd253, 8'd253, 8'd253);
		send_pixel(8'd255, 8'd255, 8'd255);
	endtask

	// most negative weights: the sum goes below zero
	task automatic test_negative_sum();
		set_weights(16'h8000, 16'h8000, 16'h8000);
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd200, 8'd10, 8'd90);
	endtask

	// a write to the spare register index must leave the weights alone
	task automatic test_unused_index();
		set_weights(16'h1000, 16'hF800, 16'h0400);
		write_reg(REG_UNUSED, 16'h7FFF);
		send_pixel(8'd40, 8'd90, 8'd160);
		send_pixel(8'd0, 8'd255, 8'd0);
	endtask

	// random pixels under several weight sets, some phases without idling
	task automatic test_random_pixels();
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				0: set_weights(16'd7700, -16'sd4178, -16'sd2253);   // hematoxylin-like
				1: set_weights(-16'sd287, 16'd4628, -16'sd532);     // eosin-like
				2, 3, 4, 5: set_weights(draw_weight(6144), draw_weight(6144), draw_weight(6144));
				default: set_weights(16'($urandom_range(0, 65535)),
					16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
			endcase
			idle_enabled = (ph % 3) != 1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_pixel(draw_channel(), draw_channel(), draw_channel());
		end
		idle_enabled = 1'b1;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		cfg_wr_en     = 1'b0;
		cfg_index     = REG_RED;
		cfg_data      = '0;
		red_weight    = 0;
		green_weight  = 0;
		blue_weight   = 0;
		build_luts();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_weights();
		test_single_channel();
		test_saturated_sum();
		test_negative_sum();
		test_unused_index();
		test_random_pixels();

		settle();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0 && expected_levels.size() == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
